### rtl/core/olist_pkg.sv
// Shared constants, request and status codes, and the probe record for the ordered list engine.
package olist_pkg;

    // Storage and field geometry.
    localparam int CAPACITY    = 64;
    localparam int DATA_W      = 32;
    localparam int REQ_W       = 3;
    localparam int POS_W       = 6;
    localparam int STATUS_W    = 2;
    localparam int OUT_COUNT_W = 7;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    // Width used when cell indexes, counts and positions are compared.
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_APPEND       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ         = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CONTAINS     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE_VALUE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REMOVE_AT    = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    // A request as it travels down the cell chain.
    typedef struct packed {
        logic              active;
        logic [REQ_W-1:0]  req;
        logic [DATA_W-1:0] key;
        logic [POS_W-1:0]  pos;
        logic [CNT_W-1:0]  count;
        logic              hit;
        logic [DATA_W-1:0] value;
    } probe_t;

endpackage

### rtl/core/olist_cell.sv
// One list cell: holds one entry and serves the probe that passes it on its way down the chain.
module olist_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [olist_pkg::CNT_W-1:0]  cell_idx,
    input  olist_pkg::probe_t         probe_in,
    input  logic [olist_pkg::DATA_W-1:0] next_value,
    output olist_pkg::probe_t         probe_out,
    output logic [olist_pkg::DATA_W-1:0] value_out
);
    import olist_pkg::*;

    logic [DATA_W-1:0] value_reg, value_next;
    probe_t            probe_reg, probe_next;
    logic [CMP_W-1:0]  idx_ext, cnt_ext, pos_ext;
    logic              in_range, at_pos, key_match, hit_here, removing;

    assign idx_ext   = CMP_W'(cell_idx);
    assign cnt_ext   = CMP_W'(probe_in.count);
    assign pos_ext   = CMP_W'(probe_in.pos);
    assign in_range  = idx_ext < cnt_ext;
    assign at_pos    = (idx_ext == pos_ext) && in_range;
    // Only the first equal entry counts, so a hit earlier in the chain masks this one.
    assign key_match = !probe_in.hit && in_range && (value_reg == probe_in.key);
    assign removing  = (probe_in.req == REQ_REMOVE_VALUE) || (probe_in.req == REQ_REMOVE_AT);

    always_comb begin
        case (probe_in.req)
            REQ_APPEND:                     hit_here = (idx_ext == cnt_ext);
            REQ_READ, REQ_REMOVE_AT:        hit_here = at_pos;
            REQ_CONTAINS, REQ_REMOVE_VALUE: hit_here = key_match;
            default:                        hit_here = 1'b0;
        endcase
    end

    always_comb begin
        value_next = value_reg;
        probe_next = probe_in;
        if (probe_in.active) begin
            if (hit_here) begin
                probe_next.hit = 1'b1;
                if (probe_in.req != REQ_APPEND) begin
                    probe_next.value = value_reg;
                end
            end
            if ((probe_in.req == REQ_APPEND) && hit_here) begin
                value_next = probe_in.key;
            end
            // From the removed entry onward each cell takes its upper neighbor's old value.
            if (removing && (probe_in.hit || hit_here) && in_range) begin
                value_next = next_value;
            end
        end
    end

    // Only the active flag is reset; the rest of the probe and the entry are don't-care
    // until a request writes them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg.active <= 1'b0;
        end else begin
            probe_reg.active <= probe_next.active;
        end
        value_reg       <= value_next;
        probe_reg.req   <= probe_next.req;
        probe_reg.key   <= probe_next.key;
        probe_reg.pos   <= probe_next.pos;
        probe_reg.count <= probe_next.count;
        probe_reg.hit   <= probe_next.hit;
        probe_reg.value <= probe_next.value;
    end

    assign probe_out = probe_reg;
    assign value_out = value_reg;

endmodule

### rtl/core/ordered_list_engine_unit.sv
// Top level of the ordered list engine: request intake, cell chain, entry count and result buffering.
//
//  Channel  | Direction | Handshake          | Payload (lowest bit first)
//  ---------+-----------+--------------------+-----------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | req_type[2:0], item_value[34:3], position[40:35]
//  m_       | out       | m_tvalid/m_tready  | status[1:0], result_value[33:2], entry_count[40:34]
//
// A request walks the chain of CAPACITY cells, one cell per cycle, and is registered in each
// cell; the next request can be accepted only once the result of the last one has left the
// final cell, so the engine takes no new request while one is still in the chain.
// Reset clears the entry count and all handshake state; the cell contents are not cleared,
// since only positions below the count are ever read.
// A stalled result waits in the output register while a second result can be parked in a
// holding register; input is refused only while a request is in the chain or that holding
// register is full.
module ordered_list_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // req_type[2:0], item_value[34:3], position[40:35], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], result_value[33:2], entry_count[40:34], zeros
);
    import olist_pkg::*;

    localparam int S_BITS = REQ_W + DATA_W + POS_W;
    localparam int M_BITS = STATUS_W + DATA_W + OUT_COUNT_W;

    // The probe array has one slot per cell boundary: slot 0 feeds the first cell and the
    // last slot is the registered probe leaving the final cell.
    probe_t            probe_chain [CAPACITY+1];
    logic [DATA_W-1:0] cell_value  [CAPACITY];
    logic [DATA_W-1:0] cell_next   [CAPACITY];
    logic [CAPACITY-1:0] probe_active;

    logic                   busy_reg, busy_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [DATA_W-1:0]      out_value_reg, out_value_next;
    logic [OUT_COUNT_W-1:0] out_count_reg, out_count_next;
    logic [STATUS_W-1:0]    pend_status_reg, pend_status_next;
    logic [DATA_W-1:0]      pend_value_reg, pend_value_next;
    logic [OUT_COUNT_W-1:0] pend_count_reg, pend_count_next;

    logic                   s_accept;
    logic                   out_free;
    probe_t                 fin;
    logic [STATUS_W-1:0]    fin_status;
    logic [CNT_W-1:0]       fin_count;
    logic [DATA_W-1:0]      fin_value;

    // The chain serves one request at a time, so input is held off while one is in flight.
    assign s_tready = !busy_reg && !pend_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    // The first cell works on the accepted transaction directly from the input bus.
    always_comb begin
        probe_chain[0].active = s_accept;
        probe_chain[0].req    = s_tdata[REQ_W-1:0];
        probe_chain[0].key    = s_tdata[REQ_W+DATA_W-1:REQ_W];
        probe_chain[0].pos    = s_tdata[S_BITS-1:REQ_W+DATA_W];
        probe_chain[0].count  = count_reg;
        probe_chain[0].hit    = 1'b0;
        probe_chain[0].value  = '0;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        // The top cell has no upper neighbor; its own value stands in and is never kept.
        if (g < CAPACITY - 1) begin : g_inner
            assign cell_next[g] = cell_value[g+1];
        end else begin : g_top
            assign cell_next[g] = cell_value[g];
        end

        olist_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_idx   (CNT_W'(g)),
            .probe_in   (probe_chain[g]),
            .next_value (cell_next[g]),
            .probe_out  (probe_chain[g+1]),
            .value_out  (cell_value[g])
        );

        assign probe_active[g] = probe_chain[g+1].active;
    end

    // A probe that leaves the last cell carries everything needed for the result.
    assign fin = probe_chain[CAPACITY];

    always_comb begin
        if (fin.hit) begin
            fin_status = STATUS_OK;
        end else if (fin.req == REQ_APPEND) begin
            fin_status = STATUS_FULL;
        end else begin
            fin_status = STATUS_NOT_FOUND;
        end
        fin_value = fin.hit ? fin.value : '0;
        fin_count = fin.count;
        if (fin.hit) begin
            case (fin.req)
                REQ_APPEND:                      fin_count = fin.count + CNT_W'(1);
                REQ_REMOVE_VALUE, REQ_REMOVE_AT: fin_count = fin.count - CNT_W'(1);
                default:                         fin_count = fin.count;
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // A finished result goes straight to the output register when it is free, and into the
    // holding register otherwise; the holding register drains as soon as the output frees up.
    always_comb begin
        busy_next        = busy_reg;
        count_next       = count_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        pend_valid_next  = pend_valid_reg;
        out_status_next  = out_status_reg;
        out_value_next   = out_value_reg;
        out_count_next   = out_count_reg;
        pend_status_next = pend_status_reg;
        pend_value_next  = pend_value_reg;
        pend_count_next  = pend_count_reg;

        if (s_accept) begin
            busy_next = 1'b1;
        end else if (fin.active) begin
            busy_next = 1'b0;
        end

        if (fin.active) begin
            count_next = fin_count;
            if (out_free) begin
                m_tvalid_next   = 1'b1;
                out_status_next = fin_status;
                out_value_next  = fin_value;
                out_count_next  = OUT_COUNT_W'(fin_count);
            end else begin
                pend_valid_next  = 1'b1;
                pend_status_next = fin_status;
                pend_value_next  = fin_value;
                pend_count_next  = OUT_COUNT_W'(fin_count);
            end
        end else if (pend_valid_reg && out_free) begin
            m_tvalid_next   = 1'b1;
            pend_valid_next = 1'b0;
            out_status_next = pend_status_reg;
            out_value_next  = pend_value_reg;
            out_count_next  = pend_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            count_reg      <= count_next;
            m_tvalid_reg   <= m_tvalid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg  <= out_status_next;
        out_value_reg   <= out_value_next;
        out_count_reg   <= out_count_next;
        pend_status_reg <= pend_status_next;
        pend_value_reg  <= pend_value_next;
        pend_count_reg  <= pend_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(48-M_BITS){1'b0}}, out_count_reg, out_value_reg, out_status_reg};

    // At most one request is ever inside the cell chain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(probe_active) <= 1)
        else $error("more than one request in the cell chain");

    // A request can only leave the chain while the engine counts itself busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fin.active |-> busy_reg)
        else $error("result left the chain with no request outstanding");

    // The entry count never passes the capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A store-full result only comes from a full store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fin.active && (fin_status == STATUS_FULL)) |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("store full reported below capacity");

    // The holding register is only used behind an occupied output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> m_tvalid_reg)
        else $error("held result with an empty output register");

endmodule
